>>> rtl/jfhs_pkg.sv
// Shared types and constants for the joint flag homing sequencer.
// No dependencies; every other rtl file imports this package.
`default_nettype none

package jfhs_pkg;

    localparam int POS_W = 32;
    localparam int DEB_W = 16;
    localparam int PER_W = 20;
    localparam int CFG_IDX_W = 2;

    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd200;
    localparam logic [PER_W-1:0] PERIOD_RESET = 20'd500;
    localparam logic [PER_W-1:0] TIMER_MAX = {PER_W{1'b1}};

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEARCH_VELOCITY = 2'd0,
        CFG_DEBOUNCE_TICKS  = 2'd1,
        CFG_PUBLISH_PERIOD  = 2'd2
    } cfg_idx_t;

    // Input operations
    typedef enum logic {
        OP_TICK    = 1'b0,
        OP_RESTART = 1'b1
    } op_t;

    // Homing phases
    typedef enum logic [2:0] {
        PH_INIT  = 3'd0,
        PH_BEGIN = 3'd1,
        PH_LOW   = 3'd2,
        PH_HIGH  = 3'd3,
        PH_CAL   = 3'd4
    } phase_t;

    typedef struct packed {
        logic signed [POS_W-1:0] search_velocity;
        logic [DEB_W-1:0]        debounce_ticks;
        logic [PER_W-1:0]        publish_period;
    } cfg_t;

    typedef struct packed {
        phase_t                  phase;
        logic [DEB_W-1:0]        debounce_count;
        logic signed [POS_W-1:0] start_position;
        logic signed [POS_W-1:0] offset;
        logic signed [POS_W-1:0] command;
        logic [PER_W-1:0]        publish_timer;
    } seq_state_t;

    typedef struct packed {
        logic                    operation;
        logic                    flag_level;
        logic signed [POS_W-1:0] joint_position;
        logic signed [POS_W-1:0] edge_position;
    } tick_t;

    typedef struct packed {
        logic publish_pulse;
        logic wrong_edge;
    } step_flags_t;

endpackage

`default_nettype wire

>>> rtl/jfhs_cfg_regs.sv
// Configuration register file of the homing sequencer.
// Depends on jfhs_pkg for the register indexes and the cfg_t bundle.
`default_nettype none

module jfhs_cfg_regs
    import jfhs_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 wr_en,
    input  wire logic [CFG_IDX_W-1:0] wr_index,
    input  wire logic [POS_W-1:0]     wr_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.search_velocity <= '0;
            cfg_reg.debounce_ticks  <= DEBOUNCE_RESET;
            cfg_reg.publish_period  <= PERIOD_RESET;
        end else if (wr_en) begin
            case (cfg_idx_t'(wr_index))
                CFG_SEARCH_VELOCITY: cfg_reg.search_velocity <= wr_data;
                CFG_DEBOUNCE_TICKS:  cfg_reg.debounce_ticks  <= wr_data[DEB_W-1:0];
                CFG_PUBLISH_PERIOD:  cfg_reg.publish_period  <= wr_data[PER_W-1:0];
                default: ; // drop writes beyond the register list
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> rtl/jfhs_step.sv
// Next-state logic of the homing sequencer for one control tick.
// Depends on jfhs_pkg; purely combinational.
`default_nettype none

module jfhs_step
    import jfhs_pkg::*;
(
    input  wire cfg_t        cfg,
    input  wire seq_state_t  cur,
    input  wire tick_t       tick,
    output seq_state_t  nxt,
    output step_flags_t flags
);

    logic signed [POS_W-1:0] neg_velocity;
    logic signed [POS_W:0]   travel;
    logic                    vel_pos;
    logic                    vel_neg;
    logic                    wrong_way;

    always_comb begin
        // saturate the negation of the most negative value
        if (cfg.search_velocity == {1'b1, {(POS_W-1){1'b0}}}) begin
            neg_velocity = {1'b0, {(POS_W-1){1'b1}}};
        end else begin
            neg_velocity = -cfg.search_velocity;
        end
        travel = {tick.joint_position[POS_W-1], tick.joint_position}
               - {cur.start_position[POS_W-1], cur.start_position};
        vel_pos = !cfg.search_velocity[POS_W-1] && (cfg.search_velocity != '0);
        vel_neg = cfg.search_velocity[POS_W-1];
        wrong_way = (vel_pos && travel[POS_W])
                 || (vel_neg && !travel[POS_W] && (travel != '0));
    end

    always_comb begin
        nxt   = cur;
        flags = '0;
        if (op_t'(tick.operation) == OP_RESTART) begin
            nxt.phase  = PH_INIT;
            nxt.offset = '0;
        end else begin
            if (cur.phase == PH_CAL && cur.publish_timer >= cfg.publish_period) begin
                flags.publish_pulse = 1'b1;
                nxt.publish_timer   = PER_W'(1);
            end else if (cur.publish_timer != TIMER_MAX) begin
                nxt.publish_timer = cur.publish_timer + PER_W'(1);
            end

            case (cur.phase)
                PH_BEGIN: begin
                    if (tick.flag_level) begin
                        nxt.phase          = PH_LOW;
                        nxt.debounce_count = cfg.debounce_ticks;
                    end else begin
                        nxt.phase          = PH_HIGH;
                        nxt.start_position = tick.joint_position;
                    end
                end
                PH_LOW: begin
                    nxt.command = neg_velocity;
                    if (!tick.flag_level) begin
                        if (cur.debounce_count <= DEB_W'(1)) begin
                            nxt.debounce_count = '0;
                            nxt.phase          = PH_HIGH;
                            nxt.start_position = tick.joint_position;
                        end else begin
                            nxt.debounce_count = cur.debounce_count - DEB_W'(1);
                        end
                    end else begin
                        nxt.debounce_count = cfg.debounce_ticks;
                    end
                end
                PH_HIGH: begin
                    nxt.command = cfg.search_velocity;
                    if (tick.flag_level) begin
                        if (wrong_way) begin
                            nxt.phase        = PH_BEGIN;
                            flags.wrong_edge = 1'b1;
                        end else begin
                            nxt.offset  = tick.edge_position;
                            nxt.phase   = PH_CAL;
                            nxt.command = '0;
                        end
                    end
                end
                PH_CAL: ;
                default: begin
                    // initialized and undefined codes: stop and start over
                    nxt.command = '0;
                    nxt.phase   = PH_BEGIN;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/joint_flag_homing_sequencer_unit.sv
// Top level of the joint flag homing sequencer: input register, step logic,
// result register and configuration port. Depends on jfhs_pkg, jfhs_cfg_regs
// and jfhs_step.
`default_nettype none

// Homing sequencer for one joint with a reference flag. Each transfer on the
// s_ channel is one control tick (or a restart) and produces exactly one
// transfer on the m_ channel, in order. The block accepts one item per clock:
// a transfer is held in the input register until the result register can
// take it, the step logic computes the next sequencer state from it, and the
// state and the result are written together into the state and result
// registers, the latter driving the m_ channel. The sustained rate is one
// item per cycle, limited only by the m_ready back-pressure seen through the
// result register. Configuration writes on the cfg_ channel are always
// accepted (cfg_ready is tied high) and take effect on the next item; write
// them only while no item is in flight. Writes to indexes past the last
// register are ignored. All positions and velocities are Q16.16.
module joint_flag_homing_sequencer_unit
    import jfhs_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,

    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [POS_W-1:0]         cfg_data,

    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic                     s_operation,
    input  wire logic                     s_flag_level,
    input  wire logic signed [POS_W-1:0]  s_joint_position,
    input  wire logic signed [POS_W-1:0]  s_edge_position,

    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic signed [POS_W-1:0]       m_velocity_command,
    output logic                          m_loop_enable,
    output logic                          m_calibrated,
    output logic signed [POS_W-1:0]       m_zero_offset,
    output logic                          m_publish_pulse,
    output logic                          m_wrong_edge,
    output logic [2:0]                    m_phase
);

    cfg_t        cfg;
    tick_t       tick_reg;
    logic        tick_valid_reg;
    seq_state_t  state_reg;
    seq_state_t  state_next;
    step_flags_t flags_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        advance;

    // -------------------------------------------------------------------
    // Configuration port
    // -------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    jfhs_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // -------------------------------------------------------------------
    // Flow control: advance moves the held tick through the step logic into
    // the result register. The input register takes a new transfer whenever
    // it is empty or is draining this cycle.
    // -------------------------------------------------------------------
    assign advance = tick_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !tick_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_valid_reg <= 1'b0;
        end else if (s_ready) begin
            tick_valid_reg <= s_valid;
        end
    end

    // payload needs no reset; capture on every transfer
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            tick_reg.operation      <= s_operation;
            tick_reg.flag_level     <= s_flag_level;
            tick_reg.joint_position <= s_joint_position;
            tick_reg.edge_position  <= s_edge_position;
        end
    end

    // -------------------------------------------------------------------
    // Step logic
    // -------------------------------------------------------------------
    jfhs_step u_step (
        .cfg   (cfg),
        .cur   (state_reg),
        .tick  (tick_reg),
        .nxt   (state_next),
        .flags (flags_next)
    );

    // Sequencer state: commit only when the tick actually moves on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase          <= PH_INIT;
            state_reg.debounce_count <= DEBOUNCE_RESET;
            state_reg.start_position <= '0;
            state_reg.offset         <= '0;
            state_reg.command        <= '0;
            state_reg.publish_timer  <= PERIOD_RESET;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // -------------------------------------------------------------------
    // Result register: hold while the consumer stalls, drop after transfer
    // -------------------------------------------------------------------
    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_velocity_command <= state_next.command;
            m_loop_enable      <= (state_next.phase != PH_CAL);
            m_calibrated       <= (state_next.phase == PH_CAL);
            m_zero_offset      <= state_next.offset;
            m_publish_pulse    <= flags_next.publish_pulse;
            m_wrong_edge       <= flags_next.wrong_edge;
            m_phase            <= state_next.phase;
        end
    end

    assign m_valid = out_valid_reg;

    // -------------------------------------------------------------------
    // Assertions
    // -------------------------------------------------------------------
    // The offset is only ever set on entry to calibrated and cleared on restart
    a_offset_only_when_cal: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.phase != PH_CAL) |-> (state_reg.offset == '0))
        else $error("zero offset nonzero outside calibrated phase");

    // A committed restart leaves the sequencer initialized with no offset
    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && tick_reg.operation == OP_RESTART)
        |=> (state_reg.phase == PH_INIT && state_reg.offset == '0))
        else $error("restart did not reset phase and offset");

    // A wrong-edge report always sends the sequence back to beginning
    a_wrong_edge_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_wrong_edge) |-> (m_phase == PH_BEGIN && !m_calibrated))
        else $error("wrong edge reported without return to beginning");

    // Publish strobes only come from the calibrated phase
    a_pulse_when_cal: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_publish_pulse) |-> (m_calibrated && !m_loop_enable))
        else $error("publish pulse outside calibrated phase");

endmodule

`default_nettype wire

>>> test/joint_flag_homing_sequencer_unit_test.sv
// Self-checking testbench for joint_flag_homing_sequencer_unit: directed homing paths,
// a long debounce and randomized homing sequences under idling and back-pressure.
// Depends on jfhs_pkg and the rtl top level only.
`timescale 1ns / 1ps

module joint_flag_homing_sequencer_unit_test;
    import jfhs_pkg::*;

    localparam int QUIET_LIMIT = 5000;     // cycles without any transfer before giving up
    localparam int TAIL_CYCLES = 8;        // wait past the last result for strays
    localparam int RANDOM_ROUNDS = 8;
    localparam int ROUND_ITEMS = 100;
    localparam int LONG_DEBOUNCE = 120;
    localparam logic signed [POS_W-1:0] MOST_NEG = 32'sh8000_0000;
    localparam logic signed [POS_W-1:0] MOST_POS = 32'sh7FFF_FFFF;
    localparam logic signed [POS_W-1:0] ONE_Q16 = 32'sh0001_0000;

    typedef struct packed {
        logic signed [POS_W-1:0] velocity_command;
        logic                    loop_enable;
        logic                    calibrated;
        logic signed [POS_W-1:0] zero_offset;
        logic                    publish_pulse;
        logic                    wrong_edge;
        phase_t                  phase;
    } homing_result_t;

    logic aclk = 1'b0;
    logic aresetn;

    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [POS_W-1:0]        cfg_data;

    logic                    s_valid;
    logic                    s_ready;
    logic                    s_operation;
    logic                    s_flag_level;
    logic signed [POS_W-1:0] s_joint_position;
    logic signed [POS_W-1:0] s_edge_position;

    logic                    m_valid;
    logic                    m_ready;
    logic signed [POS_W-1:0] m_velocity_command;
    logic                    m_loop_enable;
    logic                    m_calibrated;
    logic signed [POS_W-1:0] m_zero_offset;
    logic                    m_publish_pulse;
    logic                    m_wrong_edge;
    logic [2:0]              m_phase;

    // Settings as the block should currently hold them
    logic signed [POS_W-1:0] cf_velocity;
    logic [DEB_W-1:0]        cf_debounce;
    logic [PER_W-1:0]        cf_period;

    // Sequencer state as the block should currently hold it
    phase_t                  hm_phase;
    logic [DEB_W-1:0]        hm_debounce;
    logic signed [POS_W-1:0] hm_start;
    logic signed [POS_W-1:0] hm_offset;
    logic signed [POS_W-1:0] hm_command;
    logic [PER_W-1:0]        hm_timer;

    homing_result_t pending_results[$];

    int send_idle_pct = 0;
    int stall_pct = 0;
    int items_sent = 0;
    int results_checked = 0;
    int mismatches = 0;
    int calibrations = 0;
    int wrong_edges = 0;
    int pulses = 0;
    int quiet_cycles = 0;
    bit was_calibrated = 1'b0;

    joint_flag_homing_sequencer_unit uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_operation        (s_operation),
        .s_flag_level       (s_flag_level),
        .s_joint_position   (s_joint_position),
        .s_edge_position    (s_edge_position),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_velocity_command (m_velocity_command),
        .m_loop_enable      (m_loop_enable),
        .m_calibrated       (m_calibrated),
        .m_zero_offset      (m_zero_offset),
        .m_publish_pulse    (m_publish_pulse),
        .m_wrong_edge       (m_wrong_edge),
        .m_phase            (m_phase)
    );

    always #5 aclk = ~aclk;

    // Advance the expected sequencer state by one accepted transfer and
    // return the result the block must produce for it.
    function automatic homing_result_t predict_homing_step(
        input op_t                     op,
        input bit                      flag,
        input logic signed [POS_W-1:0] pos,
        input logic signed [POS_W-1:0] epos
    );
        homing_result_t r;
        phase_t start_phase;
        logic signed [POS_W:0] travel;
        r.publish_pulse = 1'b0;
        r.wrong_edge = 1'b0;
        if (op == OP_RESTART) begin
            // Restart keeps command, timer, debounce count and start position
            hm_phase = PH_INIT;
            hm_offset = '0;
        end else begin
            start_phase = hm_phase;
            // The publish timer runs in every phase and saturates at the top
            if (start_phase == PH_CAL && hm_timer >= cf_period) begin
                r.publish_pulse = 1'b1;
                hm_timer = PER_W'(1);
            end else if (hm_timer != TIMER_MAX) begin
                hm_timer = hm_timer + 1'b1;
            end
            case (start_phase)
                PH_BEGIN: begin
                    if (flag) begin
                        hm_phase = PH_LOW;
                        hm_debounce = cf_debounce;
                    end else begin
                        hm_phase = PH_HIGH;
                        hm_start = pos;
                    end
                end
                PH_LOW: begin
                    // Negation saturates for the most negative speed
                    hm_command = (cf_velocity == MOST_NEG) ? MOST_POS : -cf_velocity;
                    if (flag) begin
                        hm_debounce = cf_debounce;
                    end else if (hm_debounce < DEB_W'(2)) begin
                        hm_debounce = '0;
                        hm_phase = PH_HIGH;
                        hm_start = pos;
                    end else begin
                        hm_debounce = hm_debounce - 1'b1;
                    end
                end
                PH_HIGH: begin
                    hm_command = cf_velocity;
                    if (flag) begin
                        // Exact travel since the start position, one bit wider
                        travel = {pos[POS_W-1], pos} - {hm_start[POS_W-1], hm_start};
                        if ((cf_velocity > 0 && travel < 0) ||
                            (cf_velocity < 0 && travel > 0)) begin
                            hm_phase = PH_BEGIN;
                            r.wrong_edge = 1'b1;
                        end else begin
                            hm_offset = epos;
                            hm_phase = PH_CAL;
                            hm_command = '0;
                        end
                    end
                end
                PH_CAL: begin
                end
                default: begin
                    hm_command = '0;
                    hm_phase = PH_BEGIN;
                end
            endcase
        end
        r.velocity_command = hm_command;
        r.loop_enable = (hm_phase != PH_CAL);
        r.calibrated = (hm_phase == PH_CAL);
        r.zero_offset = hm_offset;
        r.phase = hm_phase;
        return r;
    endfunction

    // Offer one item, hold it until the transfer, then record its expected result.
    // Valid is only dropped while idling, so back-to-back items keep it high.
    task automatic send_tick(
        input op_t                     op,
        input bit                      flag,
        input logic signed [POS_W-1:0] pos,
        input logic signed [POS_W-1:0] epos
    );
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_flag_level <= flag;
        s_joint_position <= pos;
        s_edge_position <= epos;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        pending_results.push_back(predict_homing_step(op, flag, pos, epos));
        items_sent++;
    endtask

    // Drop valid and wait until every expected result has come back.
    task automatic drain_items();
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [POS_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        case (idx)
            CFG_SEARCH_VELOCITY: cf_velocity = value;
            CFG_DEBOUNCE_TICKS:  cf_debounce = value[DEB_W-1:0];
            CFG_PUBLISH_PERIOD:  cf_period = value[PER_W-1:0];
            default: begin
            end
        endcase
    endtask

    // Program all three registers while the block is idle.
    task automatic load_settings(
        input logic signed [POS_W-1:0] vel,
        input logic [DEB_W-1:0]        deb,
        input logic [PER_W-1:0]        per
    );
        drain_items();
        write_reg(CFG_SEARCH_VELOCITY, vel);
        write_reg(CFG_DEBOUNCE_TICKS, POS_W'(deb));
        write_reg(CFG_PUBLISH_PERIOD, POS_W'(per));
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            1: begin send_idle_pct = 59; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 59; end
            3: begin send_idle_pct = 16; stall_pct = 16; end
            default: begin send_idle_pct = 0; stall_pct = 0; end
        endcase
    endtask

    task automatic check_field(input string field, input logic [POS_W-1:0] want,
                               input logic [POS_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            mismatches++;
        end
    endtask

    // Reset settings: speed zero, debounce 200, period 500
    task automatic test_reset_state();
        send_tick(OP_TICK, 1'b0, MOST_POS, MOST_NEG);
        send_tick(OP_TICK, 1'b1, MOST_NEG, MOST_POS);
        send_tick(OP_TICK, 1'b0, 32'sd0, 32'sd0);
        send_tick(OP_TICK, 1'b1, -32'sd1, -32'sd1);
        send_tick(OP_RESTART, 1'b1, MOST_POS, MOST_POS);
    endtask

    // Positive search: wrong-way edge, debounce with a bounce, calibration, pulses
    task automatic test_direction_and_debounce();
        load_settings(ONE_Q16, 16'd2, 20'd1);
        send_tick(OP_RESTART, 1'b0, MOST_NEG, MOST_NEG);
        send_tick(OP_TICK, 1'b0, 32'sd0, 32'sd0);
        send_tick(OP_TICK, 1'b0, MOST_POS, 32'sd0);        // begin, flag low: to high
        send_tick(OP_TICK, 1'b0, MOST_NEG, 32'sd0);
        send_tick(OP_TICK, 1'b1, MOST_NEG, 32'sd0);        // edge hit moving backward
        send_tick(OP_TICK, 1'b1, 32'sd0, 32'sd0);          // begin, flag high: to low
        send_tick(OP_TICK, 1'b1, 32'sd0, 32'sd0);          // bounce reloads the count
        send_tick(OP_TICK, 1'b0, 32'sd0, 32'sd0);
        send_tick(OP_TICK, 1'b0, -32'sd5, 32'sd0);
        send_tick(OP_TICK, 1'b1, 32'sd5, MOST_NEG);         // good edge: calibrated
        send_tick(OP_TICK, 1'b0, 32'sd0, 32'sd0);
        send_tick(OP_TICK, 1'b1, 32'sd0, 32'sd0);
        send_tick(OP_RESTART, 1'b0, 32'sd0, 32'sd0);
    endtask

    // Most negative speed saturates on negation; zero speed is never wrong-way
    task automatic test_velocity_extremes();
        load_settings(MOST_NEG, 16'd1, 20'd3);
        send_tick(OP_TICK, 1'b0, 32'sd0, 32'sd0);
        send_tick(OP_TICK, 1'b1, 32'sd0, 32'sd0);
        send_tick(OP_TICK, 1'b0, 32'sd100, 32'sd0);
        send_tick(OP_TICK, 1'b1, 32'sd200, 32'sd0);        // moved up with a downward search
        send_tick(OP_TICK, 1'b0, 32'sd0, 32'sd0);
        send_tick(OP_TICK, 1'b1, -32'sd1, MOST_POS);
        repeat (4) send_tick(OP_TICK, 1'b0, 32'sd0, 32'sd0);
        load_settings(32'sd0, 16'd1, 20'd1);
        send_tick(OP_RESTART, 1'b0, 32'sd0, 32'sd0);
        send_tick(OP_TICK, 1'b0, 32'sd0, 32'sd0);
        send_tick(OP_TICK, 1'b0, 32'sd10, 32'sd0);
        send_tick(OP_TICK, 1'b1, 32'sd3, 32'sd77);
    endtask

    // Long debounce and largest period: count all the way down at full rate
    task automatic test_long_debounce();
        set_idling(0);
        load_settings(MOST_POS, DEB_W'(LONG_DEBOUNCE), 20'hF_FFFF);
        send_tick(OP_RESTART, 1'b0, 32'sd0, 32'sd0);
        send_tick(OP_TICK, 1'b0, 32'sd0, 32'sd0);
        send_tick(OP_TICK, 1'b1, 32'sd0, 32'sd0);
        repeat (LONG_DEBOUNCE) send_tick(OP_TICK, 1'b0, $urandom, $urandom);
        send_tick(OP_TICK, 1'b1, hm_start + 32'sd1, $urandom);
        repeat (3) send_tick(OP_TICK, $urandom_range(1), $urandom, $urandom);
        send_tick(OP_RESTART, 1'b0, 32'sd0, 32'sd0);
    endtask

    // Pick the next item from the expected phase so that most items walk a
    // homing sequence forward; a few are restarts or plain noise.
    task automatic send_random_homing_item();
        op_t op;
        bit flag;
        logic signed [POS_W-1:0] pos;
        int roll;
        int unsigned span;
        roll = $urandom_range(99);
        op = OP_TICK;
        flag = $urandom_range(1);
        pos = $urandom;
        span = $urandom_range(1 << 18);
        if (roll < 2) begin
            op = OP_RESTART;
        end else if (roll >= 5) begin
            case (hm_phase)
                PH_LOW: flag = ($urandom_range(99) < 15);
                PH_HIGH: begin
                    flag = ($urandom_range(99) < 25);
                    // Mostly travel with the search, sometimes against it
                    if (($urandom_range(99) < 75) == (cf_velocity >= 0))
                        pos = hm_start + span;
                    else
                        pos = hm_start - span;
                end
                PH_CAL: if ($urandom_range(99) < 8) op = OP_RESTART;
                default: begin
                end
            endcase
        end
        send_tick(op, flag, pos, $urandom);
    endtask

    // Rounds of random sequences, each with fresh settings and its own idling mode
    task automatic test_random_homing();
        logic signed [POS_W-1:0] vel;
        logic [DEB_W-1:0] deb;
        logic [PER_W-1:0] per;
        for (int round = 0; round < RANDOM_ROUNDS; round++) begin
            case ($urandom_range(5))
                0: vel = '0;
                1: vel = MOST_NEG;
                2: vel = MOST_POS;
                3: vel = $urandom_range(1, 32'h0040_0000);
                4: vel = 32'd0 - $urandom_range(1, 32'h0040_0000);
                default: vel = $urandom;
            endcase
            deb = ($urandom_range(4) == 0) ? DEB_W'(1) : DEB_W'($urandom_range(1, 6));
            per = ($urandom_range(4) == 0) ? PER_W'(1) : PER_W'($urandom_range(1, 12));
            load_settings(vel, deb, per);
            set_idling(round % 4);
            repeat (ROUND_ITEMS) send_random_homing_item();
        end
    endtask

    // Receiver: stall at random according to the current mode
    always @(posedge aclk)
        m_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);

    // Compare every result transfer against the oldest expectation
    always @(posedge aclk) begin : check_results
        homing_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result transfer with nothing expected, phase %0d",
                         $time, m_phase);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("velocity_command", want.velocity_command, m_velocity_command);
                check_field("loop_enable", POS_W'(want.loop_enable), POS_W'(m_loop_enable));
                check_field("calibrated", POS_W'(want.calibrated), POS_W'(m_calibrated));
                check_field("zero_offset", want.zero_offset, m_zero_offset);
                check_field("publish_pulse", POS_W'(want.publish_pulse),
                            POS_W'(m_publish_pulse));
                check_field("wrong_edge", POS_W'(want.wrong_edge), POS_W'(m_wrong_edge));
                check_field("phase", POS_W'(want.phase), POS_W'(m_phase));
                results_checked++;
                if (want.calibrated && !was_calibrated)
                    calibrations++;
                was_calibrated = want.calibrated;
                if (want.wrong_edge)
                    wrong_edges++;
                if (want.publish_pulse)
                    pulses++;
            end
        end
    end

    // Watchdog: give up when no transfer happens on any channel for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, QUIET_LIMIT, pending_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        aresetn <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_SEARCH_VELOCITY;
        cfg_data <= '0;
        s_valid <= 1'b0;
        s_operation <= OP_TICK;
        s_flag_level <= 1'b0;
        s_joint_position <= '0;
        s_edge_position <= '0;
        m_ready <= 1'b0;

        // Mirror the block's reset state and settings
        cf_velocity = '0;
        cf_debounce = DEBOUNCE_RESET;
        cf_period = PERIOD_RESET;
        hm_phase = PH_INIT;
        hm_debounce = DEBOUNCE_RESET;
        hm_start = '0;
        hm_offset = '0;
        hm_command = '0;
        hm_timer = PERIOD_RESET;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_direction_and_debounce();
        test_velocity_extremes();
        test_long_debounce();
        test_random_homing();

        drain_items();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Ran %0d ticks and restarts: reset settings, directed edge cases,",
                 items_sent);
        $display("a %0d-tick debounce and %0d random settings; checked %0d results.",
                 LONG_DEBOUNCE, RANDOM_ROUNDS, results_checked);
        $display("Saw %0d calibrations, %0d wrong-way edges, %0d pulses, %0d mismatches.",
                 calibrations, wrong_edges, pulses, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
